// ----- design/sha_pkg.sv -----
// Shared types, round constants and mixing functions for the SHA-256 hasher.
package sha_pkg;

    // Command handed from the front end to the compression engine.
    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } t_cmd;

    localparam int unsigned DOUT_W = 40;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- design/sha256_stream_hasher_unit.sv -----
// Top level of the streaming SHA-256 hasher.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------------
//  s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready| tdata[7:0]=data_byte, tuser=action
//  m_axis   | out | o_m_axis_tvalid/i_m_axis_tready| tdata[31:0]=digest_word,
//           |     |                               | [34:32]=word_index; tlast=last_word
//
// An absorb item writes its byte into the block buffer; the 64th byte of a
// block starts the 64-round core, one round per cycle, then a fold adds the
// working variables into the hash. A finish pushes the padding bytes, runs one
// or two compressions, then sends 8 output words at one per cycle unless stalled.
// The command queue keeps taking items while the core runs, until full.
// Reset (i_rst_n low, synchronous) loads the initial hash and clears the
// byte and bit counts; the block buffer itself is never cleared.
module sha256_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] action (1 = finish)
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [sha_pkg::DOUT_W-1:0] o_m_axis_tdata, // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast
);
    import sha_pkg::*;

    logic s_fv;
    logic s_fr;
    t_cmd s_fcmd;
    logic s_qv;
    logic s_qr;
    t_cmd s_qcmd;

    sha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_fin       (i_s_axis_tuser),
        .o_cmd_valid (s_fv),
        .i_cmd_ready (s_fr),
        .o_cmd       (s_fcmd)
    );

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (s_fv),
        .o_wr_ready (s_fr),
        .i_wr_cmd   (s_fcmd),
        .o_rd_valid (s_qv),
        .i_rd_ready (s_qr),
        .o_rd_cmd   (s_qcmd)
    );

    sha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_qv),
        .o_cmd_ready (s_qr),
        .i_cmd       (s_qcmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );
endmodule

// ----- design/sha_front.sv -----
// Input stage: registers stream items and classifies them into commands.
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic          i_fin,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output sha_pkg::t_cmd o_cmd
);
    import sha_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // finish items carry no byte; data is zeroed so it cannot leak downstream
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd.fin  <= i_fin;
            r_cmd.data <= i_fin ? 8'h00 : i_data;
        end
    end
endmodule

// ----- design/sha_queue.sv -----
// Small command FIFO between the front end and the compression engine.
module sha_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  sha_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output sha_pkg::t_cmd o_rd_cmd
);
    import sha_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          s_wr;
    logic          s_rd;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_cmd   = r_mem[r_rp];
    assign s_wr       = i_wr_valid && o_wr_ready;
    assign s_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (s_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (s_wr && !s_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (s_rd && !s_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- design/sha_back.sv -----
// Compression engine: block buffer, padding, 64-round core and digest output.
module sha_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_ready,
    input  sha_pkg::t_cmd              i_cmd,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sha_pkg::DOUT_W-1:0] o_data,
    output logic                       o_last
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st;
    logic [31:0] r_w [16];   // block words; doubles as the schedule shift line
    logic [31:0] r_h [8];
    logic [31:0] r_s [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_rnd;
    logic        r_fin;      // finishing: padding in progress
    logic        r_first;    // 0x80 not yet placed
    logic        r_lenph;    // length bytes under way
    logic        r_done;     // last padded block queued for compression
    logic [2:0]  r_widx;

    logic        r_ov;
    logic [31:0] r_od;
    logic [2:0]  r_oi;
    logic        r_ol;

    logic        s_take;
    logic        s_push;
    logic [7:0]  s_byte;
    logic        s_len;
    logic [31:0] s_t1;
    logic [31:0] s_t2;
    logic [31:0] s_wn;
    logic        s_oload;

    assign o_cmd_ready = (r_st == ST_IDLE);
    assign s_take      = i_cmd_valid && o_cmd_ready;
    assign s_len       = r_lenph || (r_fill == LEN_OFS);

    always_comb begin
        s_push = 1'b0;
        s_byte = 8'h00;
        if (s_take && !i_cmd.fin) begin
            s_push = 1'b1;
            s_byte = i_cmd.data;
        end else if (r_st == ST_PAD) begin
            s_push = 1'b1;
            if (r_first) begin
                s_byte = PAD_BYTE;
            end else if (s_len) begin
                // length byte k sits at offset 56+k, most significant first
                s_byte = r_bits[63 - 8 * r_fill[2:0] -: 8];
            end
        end
    end

    assign s_t1 = r_s[7] + bsig1(r_s[4]) + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
                + ROUND_K[r_rnd] + r_w[0];
    assign s_t2 = bsig0(r_s[0]) + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
    assign s_wn = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign s_oload = (r_st == ST_OUT) && (!r_ov || i_ready);

    // block buffer and schedule
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            for (int i = 0; i < 16; i++) begin
                if (r_fill[5:2] == 4'(i)) begin
                    r_w[i][31 - 8 * r_fill[1:0] -: 8] <= s_byte;
                end
            end
        end else if (r_st == ST_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= s_wn;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (r_st != ST_COMP) begin
            for (int i = 0; i < 8; i++) begin
                r_s[i] <= r_h[i];
            end
        end else begin
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + s_t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= s_t1 + s_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_oload) begin
            r_od <= r_h[r_widx];
            r_oi <= r_widx;
            r_ol <= (r_widx == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_lenph <= 1'b0;
            r_done  <= 1'b0;
            r_widx  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= IV[i];
            end
        end else begin
            if (s_oload) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (s_push) begin
                r_fill <= r_fill + 1'b1;
                if (r_fill == 6'd63) begin
                    r_st  <= ST_COMP;
                    r_rnd <= '0;
                end
            end
            case (r_st)
                ST_IDLE: begin
                    if (s_take) begin
                        if (i_cmd.fin) begin
                            r_st    <= ST_PAD;
                            r_fin   <= 1'b1;
                            r_first <= 1'b1;
                        end else begin
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                ST_PAD: begin
                    r_first <= 1'b0;
                    if (!r_first && s_len) begin
                        r_lenph <= 1'b1;
                        if (r_fill == 6'd63) begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_COMP: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) begin
                        r_st <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_s[i];
                    end
                    if (r_done) begin
                        r_st   <= ST_OUT;
                        r_widx <= '0;
                    end else if (r_fin) begin
                        r_st <= ST_PAD;
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (s_oload) begin
                        r_widx <= r_widx + 1'b1;
                        if (r_widx == 3'd7) begin
                            r_st    <= ST_IDLE;
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_fin   <= 1'b0;
                            r_lenph <= 1'b0;
                            r_done  <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= IV[i];
                            end
                        end
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_data  = {{(DOUT_W - 35){1'b0}}, r_oi, r_od};
    assign o_last  = r_ol;
endmodule

// ----- design/sha_checker.sv -----
// Port-level checks on the digest stream, bound to the top level.
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    logic [2:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_exp <= r_exp + 1'b1;
        end
    end

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[34:32] == r_exp)
        else $error("digest word out of order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast not on final word");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[39:35] == 5'd0)
        else $error("tdata fill bits set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled word changed");
endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the streaming SHA-256 hasher: byte and finish items in, digest words out.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;

    sha256_stream_hasher_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Predictor state: chaining words, current block, byte fill, running bit length
    logic [31:0]  hash_st [8];
    logic [7:0]   blk_bytes [64];
    int unsigned  blk_fill;
    logic [63:0]  msg_bits;

    t_byte_item   pending_items [$];
    t_digest_word digest_queue [$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  hold_receiver;
    bit  sender_paused;
    int  mismatches;
    int  digests_seen;
    int  items_sent;

    function automatic logic [31:0] ror32(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        end
        s = hash_st;
        for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + KTAB[i] + w[i];
            t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_st[i] = hash_st[i] + s[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            compress_blk();
            blk_fill = 0;
        end
    endtask

    // Update the predictor with one accepted item; a finish queues the 8 digest words
    task automatic predict_digest(t_byte_item it);
        logic [63:0] len;
        if (!it.fin) begin
            absorb_byte(it.data);
            msg_bits = msg_bits + 64'd8;
        end else begin
            len = msg_bits;
            absorb_byte(8'h80);
            while (blk_fill != 56)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++)
                digest_queue.push_back('{hash_st[i], 3'(i), i == 7});
            hash_st  = INIT_HASH;
            blk_fill = 0;
            msg_bits = '0;
        end
    endtask

    // Driver: offers the head of the queue, idles at random; a waiting item is held
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_digest(pending_items.pop_front());
                items_sent++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (pending_items.size() != 0 && !sender_paused
                && $urandom_range(99) >= sender_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_items[0].data;
                s_tuser  <= pending_items[0].fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each word against the oldest predicted one
    always @(posedge i_clk) begin
        t_digest_word got, exp_w;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[31:0], m_tdata[34:32], m_tlast};
                if (digest_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h idx %0d last %b",
                                 got.word, got.idx, got.last);
                end else begin
                    exp_w = digest_queue.pop_front();
                    if (got !== exp_w || m_tdata[39:35] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_w.word, exp_w.idx, exp_w.last,
                                     got.word, got.idx, got.last);
                    end
                    if (got.last) digests_seen++;
                end
            end
            m_tready <= !hold_receiver && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic queue_message(int len, bit randbytes, logic [7:0] fill);
        for (int i = 0; i < len; i++)
            pending_items.push_back('{1'b0, randbytes ? 8'($urandom) : fill});
        pending_items.push_back('{1'b1, 8'($urandom)});
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid) @(posedge i_clk);
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int left, len;
        i_rst_n = 1'b0;
        hold_receiver = 1'b0; sender_paused = 1'b0;
        mismatches = 0; digests_seen = 0; items_sent = 0;
        hash_st = INIT_HASH; blk_fill = 0; msg_bits = '0;
        sender_idle_pct = 25; receiver_idle_pct = 61;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, finish with a set data byte, byte extremes,
        // lengths around the 55/56 padding split and a full block (191 items)
        pending_items.push_back('{1'b1, 8'h00});
        pending_items.push_back('{1'b1, 8'hff});
        queue_message(1, 0, 8'h00);
        queue_message(1, 0, 8'hff);
        queue_message(3, 0, 8'ha5);
        queue_message(2, 0, 8'h5a);
        drain();
        queue_message(55, 1, 8'h00);
        queue_message(56, 1, 8'h00);
        queue_message(64, 0, 8'hff);

        // Random messages, mostly short, a few crossing block bounds;
        // the budget leaves room for the 34 items of the hold-off stretch
        left = 85;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
            if (len + 1 > left) len = left - 1;
            queue_message(len, 1, 8'h00);
            left -= len + 1;
            if (left < 60 && left + len + 1 >= 60) begin
                // Long receiver hold-off while the sender keeps offering
                drain();
                sender_idle_pct = 61; receiver_idle_pct = 25;
                hold_receiver = 1'b1;
                queue_message(20, 1, 8'h00);
                queue_message(12, 1, 8'h00);
                repeat (300) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            if (left < 30 && left + len + 1 >= 30) begin
                // Sender pauses until all digests are out, then no idling
                drain();
                sender_paused = 1'b1;
                repeat (5) @(posedge i_clk);
                sender_paused = 1'b0;
                sender_idle_pct = 0; receiver_idle_pct = 0;
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        $display("Hashed %0d messages from %0d items, incl. empty, pad-boundary and multi-block",
                 digests_seen, items_sent);
        $display("messages, with random idling, long output stalls and pauses; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sha_pkg.sv
design/sha_front.sv
design/sha_queue.sv
design/sha_back.sv
design/sha256_stream_hasher_unit.sv
design/sha_checker.sv
dv/tb_top.sv
